FILE: rtl/sha1md_pkg.sv
`timescale 1ns / 1ps
package sha1md_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [4:0][31:0] hash_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] round;
    } round_ctl_t;

    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned BLOCK_WDS  = 16;
    localparam int unsigned COUNT_W    = 61;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hEFCDAB89;
    localparam word_t IV2 = 32'h98BADCFE;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam hash_t HASH_IV = {IV4, IV3, IV2, IV1, IV0};

    function automatic word_t round_k(input logic [6:0] t);
        word_t k;
        if (t < 7'd20)
            k = K0;
        else if (t < 7'd40)
            k = K1;
        else if (t < 7'd60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

    function automatic word_t round_f(input logic [6:0] t, input word_t b, input word_t c,
                                      input word_t d);
        word_t f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t >= 7'd40 && t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

FILE: rtl/sha1md_core.sv
`timescale 1ns / 1ps
module sha1md_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1md_pkg::round_ctl_t ctl,
    input  sha1md_pkg::word_t      mem_word,
    input  sha1md_pkg::hash_t      chain,
    output sha1md_pkg::hash_t      vars
);
    import sha1md_pkg::*;

    hash_t vars_reg;
    hash_t vars_next;
    word_t sched_reg [BLOCK_WDS];
    word_t x_mix;
    word_t w_cur;
    word_t a_rot;
    word_t tmp;

    // sched_reg[0] holds w[t-16], sched_reg[15] holds w[t-1]
    always_comb
    begin
        x_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        if (ctl.round < 7'd16)
            w_cur = mem_word;
        else
            w_cur = {x_mix[30:0], x_mix[31]};
        a_rot = {vars_reg[0][26:0], vars_reg[0][31:27]};
        tmp   = a_rot + round_f(ctl.round, vars_reg[1], vars_reg[2], vars_reg[3])
                + vars_reg[4] + round_k(ctl.round) + w_cur;
        vars_next = vars_reg;
        if (ctl.load)
            vars_next = chain;
        else if (ctl.step)
        begin
            vars_next[4] = vars_reg[3];
            vars_next[3] = vars_reg[2];
            vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_next[1] = vars_reg[0];
            vars_next[0] = tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vars_reg <= '0;
        else
            vars_reg <= vars_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            for (int i = 0; i < BLOCK_WDS - 1; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[BLOCK_WDS-1] <= w_cur;
        end
    end

    assign vars = vars_reg;

endmodule

FILE: rtl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// sha-1 over a byte stream, one byte per item
// an item that does not fill a block leaves the input free for the next item; the 64th byte
// of a block starts a compression (load, 80 rounds at one per cycle, chain add)
// an end item writes padding words (up to 16) and adds a compression, twice when the
// length does not fit, then hands the digest to the output register once it is not stalled
// async active-low reset: initial hash values, zero byte count, no item pending
module sha1_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    word_t              word_reg, word_next;
    logic [3:0]         pad_idx_reg, pad_idx_next;
    logic               marker_reg, marker_next;
    logic               len_blk_reg, len_blk_next;
    logic               padding_reg, padding_next;
    logic               last_reg, last_next;
    logic [6:0]         round_reg, round_next;
    hash_t              chain_reg, chain_next;
    logic               out_valid_reg, out_valid_next;
    hash_t              digest_reg;
    logic               digest_load;

    word_t              blk_mem [BLOCK_WDS];
    word_t              rd_data_reg;
    logic [3:0]         rd_addr;
    logic               wr_en;
    logic [3:0]         wr_addr;
    word_t              wr_data;

    round_ctl_t         ctl;
    hash_t              vars;

    logic               in_acc;
    logic [5:0]         pos;
    logic [COUNT_W-1:0] cnt_after;
    logic [63:0]        bit_len;
    word_t              mark_word;

    sha1md_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .mem_word (rd_data_reg),
        .chain    (chain_reg),
        .vars     (vars)
    );

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign pos      = count_reg[5:0];
    assign bit_len  = {count_reg, 3'b000};
    assign cnt_after = byte_valid ? count_reg + COUNT_W'(1) : count_reg;

    // bytes after the fill point of word_reg are always zero
    always_comb
    begin
        if (count_reg[1:0] == 2'd0)
            mark_word = word_t'(PAD_MARK) << 24;
        else
            mark_word = word_reg | (word_t'(PAD_MARK) << {~count_reg[1:0], 3'b000});
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        pad_idx_next   = pad_idx_reg;
        marker_next    = marker_reg;
        len_blk_next   = len_blk_reg;
        padding_next   = padding_reg;
        last_next      = last_reg;
        round_next     = round_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg && out_stall;
        digest_load    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pos[5:2];
        wr_data        = word_next;
        ctl.load       = 1'b0;
        ctl.step       = 1'b0;
        ctl.round      = round_reg;
        rd_addr        = (state_reg == S_ROUND) ? round_reg[3:0] + 4'd1 : 4'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_valid)
                    begin
                        if (pos[1:0] == 2'd0)
                            word_next = {data_byte, 24'd0};
                        else
                            word_next = word_reg | (word_t'(data_byte) << {~pos[1:0], 3'b000});
                        wr_en      = (pos[1:0] == 2'd3);
                        wr_data    = word_next;
                        count_next = cnt_after;
                    end
                    if (byte_valid && pos == 6'd63)
                    begin
                        last_next    = end_of_message;
                        padding_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        pad_idx_next = cnt_after[5:2];
                        marker_next  = 1'b1;
                        len_blk_next = (cnt_after[5:3] != 3'd7);
                        padding_next = 1'b1;
                        state_next   = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                wr_en   = 1'b1;
                wr_addr = pad_idx_reg;
                if (marker_reg)
                    wr_data = mark_word;
                else if (len_blk_reg && pad_idx_reg == 4'd14)
                    wr_data = bit_len[63:32];
                else if (len_blk_reg && pad_idx_reg == 4'd15)
                    wr_data = bit_len[31:0];
                else
                    wr_data = '0;
                marker_next  = 1'b0;
                pad_idx_next = pad_idx_reg + 4'd1;
                if (pad_idx_reg == 4'd15)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.load   = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                ctl.step   = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + vars[i];
                if (padding_reg)
                begin
                    if (len_blk_reg)
                        state_next = S_OUT;
                    else
                    begin
                        // length did not fit: one more block of zeros and length
                        len_blk_next = 1'b1;
                        pad_idx_next = '0;
                        marker_next  = 1'b0;
                        state_next   = S_PAD;
                    end
                end
                else if (last_reg)
                begin
                    pad_idx_next = '0;
                    marker_next  = 1'b1;
                    len_blk_next = 1'b1;
                    padding_next = 1'b1;
                    state_next   = S_PAD;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    digest_load    = 1'b1;
                    out_valid_next = 1'b1;
                    chain_next     = HASH_IV;
                    count_next     = '0;
                    padding_next   = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pad_idx_reg   <= '0;
            marker_reg    <= 1'b0;
            len_blk_reg   <= 1'b0;
            padding_reg   <= 1'b0;
            last_reg      <= 1'b0;
            round_reg     <= '0;
            chain_reg     <= HASH_IV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pad_idx_reg   <= pad_idx_next;
            marker_reg    <= marker_next;
            len_blk_reg   <= len_blk_next;
            padding_reg   <= padding_next;
            last_reg      <= last_next;
            round_reg     <= round_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (digest_load)
            digest_reg <= chain_reg;
    end

    // block buffer: whole words written, one registered read port for the rounds
    always_ff @(posedge clk)
    begin
        if (wr_en)
            blk_mem[wr_addr] <= wr_data;
        rd_data_reg <= blk_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign digest_word0 = digest_reg[0];
    assign digest_word1 = digest_reg[1];
    assign digest_word2 = digest_reg[2];
    assign digest_word3 = digest_reg[3];
    assign digest_word4 = digest_reg[4];

endmodule

FILE: rtl/sha1md_checker.sv
`timescale 1ns / 1ps
module sha1md_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word0
);

    // a stalled digest stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("digest dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(digest_word0))
        else $error("digest changed while stalled");

    // an end item always leaves S_IDLE (to padding, or to S_LOAD when it fills a block), so no item follows next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_message |=> in_stall)
        else $error("item taken right after an end item");

    // a new digest appears only after the input side was held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("digest without a busy phase");

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word0   (digest_word0)
);
